// ===== rtl/ucd_pkg.sv =====
`timescale 1ns / 1ps

package ucd_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned CountW = 16;
  localparam int unsigned CodeW = 31;
  localparam logic [CountW-1:0] MaxCharsReset = 16'hFFFF;

  typedef enum logic [1:0] {
    KindAscii,
    KindInvalid,
    KindLead
  } ucd_kind_e;

  typedef struct packed {
    ucd_kind_e  kind;
    logic [2:0] pending;
    logic [6:0] payload;
    logic [5:0] cont;
    logic       eos;
  } ucd_item_t;

endpackage

// ===== rtl/ucd_front.sv =====
`timescale 1ns / 1ps

module ucd_front (
  input  logic [7:0]         in_byte_i,
  input  logic               eos_i,
  output ucd_pkg::ucd_item_t item_o
);

  always_comb begin
    item_o.cont = in_byte_i[5:0];
    item_o.eos = eos_i;
    item_o.kind = ucd_pkg::KindLead;
    item_o.pending = 3'd0;
    item_o.payload = 7'd0;
    case (in_byte_i) inside
      [8'd0:8'd127]: begin
        item_o.kind = ucd_pkg::KindAscii;
        item_o.payload = in_byte_i[6:0];
      end
      [8'd128:8'd192]: begin
        item_o.kind = ucd_pkg::KindInvalid;
      end
      [8'd193:8'd223]: begin
        item_o.pending = 3'd1;
        item_o.payload = {2'b00, in_byte_i[4:0]};
      end
      [8'd224:8'd239]: begin
        item_o.pending = 3'd2;
        item_o.payload = {3'b000, in_byte_i[3:0]};
      end
      [8'd240:8'd247]: begin
        item_o.pending = 3'd3;
        item_o.payload = {4'b0000, in_byte_i[2:0]};
      end
      [8'd248:8'd251]: begin
        item_o.pending = 3'd4;
        item_o.payload = {5'b00000, in_byte_i[1:0]};
      end
      [8'd252:8'd253]: begin
        item_o.pending = 3'd5;
        item_o.payload = {6'b000000, in_byte_i[0]};
      end
      default: begin
        item_o.kind = ucd_pkg::KindInvalid;
      end
    endcase
  end

endmodule

// ===== rtl/ucd_fifo.sv =====
`timescale 1ns / 1ps

module ucd_fifo #(
  parameter int unsigned Depth = ucd_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  ucd_pkg::ucd_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output ucd_pkg::ucd_item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ucd_pkg::ucd_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic wr_en, rd_en;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o = (count_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];
  assign wr_en = push_valid_i && push_ready_o;
  assign rd_en = pop_ready_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count exceeds depth");

endmodule

// ===== rtl/ucd_back.sv =====
`timescale 1ns / 1ps

module ucd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ucd_pkg::CountW-1:0]    cfg_wdata_i,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  ucd_pkg::ucd_item_t            item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ucd_pkg::CodeW-1:0]     out_code_o,
  output logic                          out_has_char_o,
  output logic                          out_last_o,
  output logic [ucd_pkg::CountW-1:0]    out_count_o
);

  localparam int unsigned CodeW = ucd_pkg::CodeW;
  localparam int unsigned CountW = ucd_pkg::CountW;

  logic [CountW-1:0] max_q;
  logic [2:0]        pend_q, pend_d;
  logic [CodeW-1:0]  acc_q, acc_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              vld_q, vld_d;
  logic [CodeW-1:0]  code_q, code_d;
  logic              has_q, has_d;
  logic              last_q, last_d;
  logic [CountW-1:0] ocnt_q, ocnt_d;
  logic              pop;
  logic              got;
  logic [CodeW-1:0]  cp;

  assign item_ready_o = !vld_q || out_ready_i;
  assign pop = item_valid_i && item_ready_o;

  always_comb begin
    pend_d = pend_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    got = 1'b0;
    cp = '0;
    if (pend_q != 3'd0) begin
      acc_d = {acc_q[CodeW-7:0], item_i.cont};
      pend_d = pend_q - 3'd1;
      if (pend_d == 3'd0) begin
        got = 1'b1;
        cp = acc_d;
      end
    end else if (cnt_q < max_q) begin
      case (item_i.kind)
        ucd_pkg::KindAscii: begin
          got = 1'b1;
          cp = CodeW'(item_i.payload);
        end
        ucd_pkg::KindLead: begin
          acc_d = CodeW'(item_i.payload);
          pend_d = item_i.pending;
        end
        default: begin
        end
      endcase
    end
    if (got) begin
      cnt_d = cnt_q + 1'b1;
      acc_d = '0;
    end

    vld_d = vld_q;
    code_d = code_q;
    has_d = has_q;
    last_d = last_q;
    ocnt_d = ocnt_q;
    if (pop) begin
      vld_d = got || item_i.eos;
      code_d = cp;
      has_d = got;
      last_d = item_i.eos;
      ocnt_d = cnt_d;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
    if (pop && item_i.eos) begin
      pend_d = 3'd0;
      acc_d = '0;
      cnt_d = '0;
    end
    if (!pop) begin
      pend_d = pend_q;
      acc_d = acc_q;
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= ucd_pkg::MaxCharsReset;
      pend_q <= 3'd0;
      acc_q <= '0;
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      pend_q <= pend_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    has_q <= has_d;
    last_q <= last_d;
    ocnt_q <= ocnt_d;
  end

  assign out_valid_o = vld_q;
  assign out_code_o = code_q;
  assign out_has_char_o = has_q;
  assign out_last_o = last_q;
  assign out_count_o = ocnt_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd5)
    else $error("pending continuation count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !has_q) |-> (code_q == '0))
    else $error("result without a character carries a nonzero code point");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && has_q) |-> (ocnt_q != '0))
    else $error("result with a character reports a zero count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && item_i.eos) |=> (pend_q == 3'd0 && cnt_q == '0 && acc_q == '0))
    else $error("decoder state not cleared after end of string");

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
`timescale 1ns / 1ps
// UTF-8 stream decoder. Bytes of a string enter on the slave stream, one per
// transaction, with tlast on the string's last byte. Each decoded code point
// leaves on the master stream; tuser tells whether a transaction carries a
// code point, and the transaction for a string's last byte always has tlast
// set and carries the final character count, with or without a code point.
// The maximum number of characters per string is written through cfg_we_i and
// cfg_wdata_i; the user must write it only while the block is idle, which the
// block does not enforce. Bytes past the limit are ignored. Throughput is one
// byte per cycle while m_axis_tready is high. Each result passes through the
// classification queue and the registered decode stage. When the receiver
// stalls, the result register holds and the queue absorbs up to QueueDepth
// bytes before s_axis_tready drops. Reset empties the queue, clears the decode
// state and sets the character limit to 65535.
module utf8_stream_decoder #(
  parameter int unsigned QueueDepth = ucd_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // code_point[30:0], char_count[46:31], zero[47]
  output logic        m_axis_tuser,   // has_char
  output logic        m_axis_tlast
);

  ucd_pkg::ucd_item_t front_item;
  ucd_pkg::ucd_item_t queue_item;
  logic               queue_valid;
  logic               queue_ready;
  logic [ucd_pkg::CodeW-1:0]  out_code;
  logic [ucd_pkg::CountW-1:0] out_count;

  ucd_front u_front (
    .in_byte_i (s_axis_tdata),
    .eos_i     (s_axis_tlast),
    .item_o    (front_item)
  );

  ucd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_ready_o (s_axis_tready),
    .push_item_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_item_o   (queue_item)
  );

  ucd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .item_valid_i   (queue_valid),
    .item_ready_o   (queue_ready),
    .item_i         (queue_item),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_code_o     (out_code),
    .out_has_char_o (m_axis_tuser),
    .out_last_o     (m_axis_tlast),
    .out_count_o    (out_count)
  );

  assign m_axis_tdata = {1'b0, out_count, out_code};

endmodule

// ===== bench/code_point_checker.sv =====
`timescale 1ns / 1ps

module code_point_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [47:0] m_tdata_i,
  input  logic        m_tuser_i,
  input  logic        m_tlast_i,
  output int          mismatches_o,
  output int          outstanding_o,
  output int          results_o,
  output int          chars_o
);

  localparam int unsigned CodeW  = ucd_pkg::CodeW;
  localparam int unsigned CountW = ucd_pkg::CountW;

  localparam logic [7:0] AsciiMax   = 8'd127;
  localparam logic [7:0] InvalidMax = 8'd192;
  localparam logic [7:0] Lead2Max   = 8'd223;
  localparam logic [7:0] Lead3Max   = 8'd239;
  localparam logic [7:0] Lead4Max   = 8'd247;
  localparam logic [7:0] Lead5Max   = 8'd251;
  localparam logic [7:0] Lead6Max   = 8'd253;

  typedef struct packed {
    logic [CodeW-1:0]  code_point;
    logic              has_char;
    logic              last;
    logic [CountW-1:0] char_count;
  } glyph_t;

  logic [2:0]        pending;
  logic [CodeW-1:0]  partial;
  logic [CountW-1:0] emitted;
  logic [CountW-1:0] limit;
  glyph_t            expected_glyphs[$];

  function automatic bit decode_byte(input logic [7:0] b, input logic eos, output glyph_t g);
    bit              got;
    logic [CodeW-1:0] cp;
    got = 1'b0;
    cp = '0;
    if (pending != 3'd0) begin
      partial = {partial[CodeW-7:0], b[5:0]};
      pending = pending - 3'd1;
      if (pending == 3'd0) begin
        got = 1'b1;
        cp = partial;
      end
    end else if (emitted < limit) begin
      if (b <= AsciiMax) begin
        got = 1'b1;
        cp = CodeW'(b);
      end else if (b <= InvalidMax) begin
      end else if (b <= Lead2Max) begin
        partial = CodeW'(b[4:0]);
        pending = 3'd1;
      end else if (b <= Lead3Max) begin
        partial = CodeW'(b[3:0]);
        pending = 3'd2;
      end else if (b <= Lead4Max) begin
        partial = CodeW'(b[2:0]);
        pending = 3'd3;
      end else if (b <= Lead5Max) begin
        partial = CodeW'(b[1:0]);
        pending = 3'd4;
      end else if (b <= Lead6Max) begin
        partial = CodeW'(b[0]);
        pending = 3'd5;
      end
    end
    if (got) begin
      emitted = emitted + 1'b1;
      partial = '0;
    end
    g.code_point = cp;
    g.has_char = got;
    g.last = eos;
    g.char_count = emitted;
    if (eos) begin
      pending = '0;
      partial = '0;
      emitted = '0;
    end
    return got || eos;
  endfunction

  function automatic int check_field(input string name, input logic [31:0] want,
                                     input logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, seen);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    glyph_t want;
    glyph_t seen;
    int     errs;
    errs = 0;
    if (!rst_ni) begin
      pending = '0;
      partial = '0;
      emitted = '0;
      limit = ucd_pkg::MaxCharsReset;
      expected_glyphs.delete();
      mismatches_o <= 0;
      outstanding_o <= 0;
      results_o <= 0;
      chars_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        seen = '{m_tdata_i[30:0], m_tuser_i, m_tlast_i, m_tdata_i[46:31]};
        results_o <= results_o + 1;
        if (seen.has_char) begin
          chars_o <= chars_o + 1;
        end
        errs += check_field("pad", 32'd0, 32'(m_tdata_i[47]));
        if (expected_glyphs.size() == 0) begin
          $error("unexpected result: code_point 0x%0h has_char %0b last %0b char_count %0d",
                 seen.code_point, seen.has_char, seen.last, seen.char_count);
          errs++;
        end else begin
          want = expected_glyphs.pop_front();
          errs += check_field("code_point", 32'(want.code_point), 32'(seen.code_point));
          errs += check_field("has_char", 32'(want.has_char), 32'(seen.has_char));
          errs += check_field("last", 32'(want.last), 32'(seen.last));
          errs += check_field("char_count", 32'(want.char_count), 32'(seen.char_count));
        end
      end
      if (cfg_we_i) begin
        limit = cfg_wdata_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        if (decode_byte(s_tdata_i, s_tlast_i, want)) begin
          expected_glyphs.push_back(want);
        end
      end
      mismatches_o <= mismatches_o + errs;
      outstanding_o <= expected_glyphs.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = ucd_pkg::QueueDepth + 8;
  localparam int unsigned PhaseBytes   = 120;

  typedef logic [7:0] text_t[$];

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = '0;
  logic        s_last = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [47:0] m_data;
  logic        m_user;
  logic        m_last;

  int          mismatches;
  int          outstanding;
  int          results;
  int          chars;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned strings_sent = 0;
  int unsigned phase_bytes = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  utf8_stream_decoder uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last)
  );

  code_point_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_tvalid_i    (s_valid),
    .s_tready_i    (s_ready),
    .s_tdata_i     (s_data),
    .s_tlast_i     (s_last),
    .m_tvalid_i    (m_valid),
    .m_tready_i    (m_ready),
    .m_tdata_i     (m_data),
    .m_tuser_i     (m_user),
    .m_tlast_i     (m_last),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .results_o     (results),
    .chars_o       (chars)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  always @(posedge clk) begin
    m_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < send_idle) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= b;
    s_last <= eos;
    do @(posedge clk); while (!s_ready);
    bytes_sent++;
    phase_bytes++;
  endtask

  task automatic send_string(input text_t text);
    foreach (text[i]) begin
      send_byte(text[i], i == text.size() - 1);
    end
    strings_sent++;
  endtask

  task automatic wait_idle();
    s_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] lead_for(input int len);
    case (len)
      1: return 8'($urandom_range(0, 127));
      2: return 8'($urandom_range(193, 223));
      3: return 8'($urandom_range(224, 239));
      4: return 8'($urandom_range(240, 247));
      5: return 8'($urandom_range(248, 251));
      default: return 8'($urandom_range(252, 253));
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(99) < 70) begin
      return {2'b10, 6'($urandom_range(63))};
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(4))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'($urandom_range(2, 8));
      3: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic random_string();
    text_t text;
    int    n_chars;
    int    len;
    int    mode;
    n_chars = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
    for (int i = 0; i < n_chars; i++) begin
      len = ($urandom_range(99) < 40) ? 1 : $urandom_range(2, 6);
      text.push_back(lead_for(len));
      repeat (len - 1) text.push_back(cont_byte());
      if ($urandom_range(99) < 8) begin
        text.push_back(8'($urandom_range(255)));
      end
    end
    mode = $urandom_range(99);
    if (mode < 10) begin
      // The string ends inside a multi-byte sequence.
      len = $urandom_range(2, 6);
      text.push_back(lead_for(len));
      repeat ($urandom_range(len - 2)) text.push_back(cont_byte());
    end else if (mode < 15) begin
      text.push_back(($urandom_range(1) == 0) ? 8'($urandom_range(128, 192))
                                               : 8'($urandom_range(254, 255)));
    end
    send_string(text);
  endtask

  initial begin
    while (cycles < CycleLimit) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 24;
    recv_idle <= 83;

    write_limit(ucd_pkg::MaxCharsReset);
    send_string('{8'h00, 8'h7F, 8'hC1, 8'hFF, 8'hEF, 8'hBF, 8'hBF, 8'h80, 8'hC0, 8'hFE,
                  8'hFF, 8'hFD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_string('{8'hF8, 8'h80});
    // A sequence begun under a high limit must complete after the limit drops.
    send_byte(8'hE2, 1'b0);
    write_limit(16'd0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b1);
    send_string('{8'h41, 8'h42});
    write_limit(16'd1);
    send_string('{8'h41, 8'hC3, 8'hA9});

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 24;
          recv_idle <= 83;
        end
        1: begin
          send_idle = 83;
          recv_idle <= 24;
        end
        default: begin
          send_idle = 0;
          recv_idle <= 0;
        end
      endcase
      phase_bytes = 0;
      write_limit(pick_limit());
      while (phase_bytes < PhaseBytes) begin
        if ($urandom_range(5) == 0) begin
          write_limit(pick_limit());
        end
        random_string();
      end
      wait_idle();
    end

    $display("Sent %0d bytes in %0d strings; checked %0d results, %0d of them code points.",
             bytes_sent, strings_sent, results, chars);
    $display("Limits ranged from 0 to 65535 under three patterns of idle cycles.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
